// File: hdl/flywheel_velocity_feedforward_macros.svh
// Assertion macros for the flywheel velocity feedforward block.
// Included by the top level; expects signals named clk and rst_n in scope.
`ifndef FLYWHEEL_VELOCITY_FEEDFORWARD_MACROS_SVH
`define FLYWHEEL_VELOCITY_FEEDFORWARD_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define FVF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define FVF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/fvf_pkg.sv
// Shared types, constants and the microcode program of the flywheel controller.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package fvf_pkg;

  // Full power applies below max_velocity / FULL_POWER_DIVISOR.
  localparam int FULL_POWER_DIVISOR = 3;

  // Velocity scale: counts per tick to rpm numerator.
  localparam logic [9:0] VEL_SCALE = 10'd600;

  localparam logic [6:0]  POWER_MAX     = 7'd127;
  localparam logic [6:0]  POWER_REVERSE = 7'd20;
  localparam logic [12:0] ELAPSED_MAX   = 13'h1FFF;

  // Serial divider: quotient bits produced, one per step.
  localparam int DIV_BITS  = 16;
  localparam int DIV_CNT_W = $clog2(DIV_BITS);

  // Register indexes of the configuration port.
  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_LOOP_PERIOD  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ERROR_GAIN   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VEL_GAIN     = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_POWER  = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_THRESH = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_VEL      = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_READY_BAND   = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_READY_DWELL  = 4'd7;
  localparam int CFG_DATA_W = 16;

  typedef struct packed {
    logic [7:0]  loop_period_ms;
    logic [9:0]  error_gain_q8;
    logic [15:0] velocity_gain_q16;
    logic [6:0]  accel_power;
    logic [9:0]  accel_threshold;
    logic [11:0] max_velocity;
    logic [7:0]  ready_band;
    logic [11:0] ready_dwell_ms;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    loop_period_ms:    8'd20,
    error_gain_q8:     10'd77,
    velocity_gain_q16: 16'd7114,
    accel_power:       7'd40,
    accel_threshold:   10'd100,
    max_velocity:      12'd600,
    ready_band:        8'd26,
    ready_dwell_ms:    12'd150
  };

  // Datapath operations, one per microcode step.
  typedef enum logic [3:0] {
    OP_LOAD, OP_MUL, OP_DIVINIT, OP_DIVSTEP, OP_VEL, OP_FF, OP_ERR,
    OP_CLIP, OP_SUM, OP_POW, OP_NOP, OP_EMIT
  } op_t;

  // Jump conditions; a true condition loads the target, else the step advances.
  typedef enum logic [2:0] {
    C_NEVER, C_ALWAYS, C_NO_IN, C_DIV_MORE, C_OUT_FULL
  } cond_t;

  localparam int STEP_W = 4;
  typedef logic [STEP_W-1:0] step_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } uword_t;

  // Sequencer to datapath.
  typedef struct packed {
    op_t  op;
    logic in_fire;
  } dp_ctrl_t;

  // Datapath to sequencer.
  typedef struct packed {
    logic div_more;
    logic out_full;
  } dp_stat_t;

  localparam step_t ST_IDLE = 4'd0;
  localparam step_t ST_DIV  = 4'd3;
  localparam step_t ST_WAIT = 4'd10;

  // Control program: one word per step.
  function automatic uword_t ucode_rom(input step_t s);
    uword_t w;
    case (s)
      4'd0:    w = '{op: OP_LOAD,    cond: C_NO_IN,    target: ST_IDLE};
      4'd1:    w = '{op: OP_MUL,     cond: C_NEVER,    target: ST_IDLE};
      4'd2:    w = '{op: OP_DIVINIT, cond: C_NEVER,    target: ST_IDLE};
      4'd3:    w = '{op: OP_DIVSTEP, cond: C_DIV_MORE, target: ST_DIV};
      4'd4:    w = '{op: OP_VEL,     cond: C_NEVER,    target: ST_IDLE};
      4'd5:    w = '{op: OP_FF,      cond: C_NEVER,    target: ST_IDLE};
      4'd6:    w = '{op: OP_ERR,     cond: C_NEVER,    target: ST_IDLE};
      4'd7:    w = '{op: OP_CLIP,    cond: C_NEVER,    target: ST_IDLE};
      4'd8:    w = '{op: OP_SUM,     cond: C_NEVER,    target: ST_IDLE};
      4'd9:    w = '{op: OP_POW,     cond: C_NEVER,    target: ST_IDLE};
      4'd10:   w = '{op: OP_NOP,     cond: C_OUT_FULL, target: ST_WAIT};
      4'd11:   w = '{op: OP_EMIT,    cond: C_ALWAYS,   target: ST_IDLE};
      default: w = '{op: OP_NOP,     cond: C_ALWAYS,   target: ST_IDLE};
    endcase
    return w;
  endfunction

endpackage

// File: hdl/flywheel_velocity_feedforward.sv
// Flywheel velocity feedforward controller, top level.
// Input stream: one transaction per control tick, carrying the encoder count
// and the goal speed. Output stream: one transaction per tick, carrying the
// motor power, the measured speed in rpm and the on-speed ready flag.
// Configuration: write-only register port, written only while idle. The user
// must keep to this; the block has no check for it. The control program
// runs one datapath operation per step and uses a 16-step serial divider
// for the velocity.
// in_tready is high only at the first step of the program.
// When the receiver stalls, the finished result waits in the output register
// and the program holds before writing the next result, so nothing is lost.
// Reset (rst_n low, synchronous) restores the register defaults, clears the
// tick history, the dwell timer and the ready flag, and empties the output.
// Depends on fvf_pkg, fvf_sequencer, fvf_datapath and the macro header.
`timescale 1ns / 1ps
`include "flywheel_velocity_feedforward_macros.svh"

module flywheel_velocity_feedforward
  import fvf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // Configuration write port.
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // Input stream.
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [47:0]           in_tdata,   // [31:0] encoder_count, [43:32] goal_velocity
  // Output stream.
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [23:0]           out_tdata   // [6:0] drive_power, [22:7] measured_velocity,
                                            // [23] ready_res
);

  cfg_t        cfg_r;
  dp_ctrl_t    ctrl;
  dp_stat_t    stat;
  logic [6:0]  drive_power;
  logic [15:0] measured_velocity;
  logic        ready_res;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LOOP_PERIOD:  cfg_r.loop_period_ms    <= cfg_wdata[7:0];
        REG_ERROR_GAIN:   cfg_r.error_gain_q8     <= cfg_wdata[9:0];
        REG_VEL_GAIN:     cfg_r.velocity_gain_q16 <= cfg_wdata[15:0];
        REG_ACCEL_POWER:  cfg_r.accel_power       <= cfg_wdata[6:0];
        REG_ACCEL_THRESH: cfg_r.accel_threshold   <= cfg_wdata[9:0];
        REG_MAX_VEL:      cfg_r.max_velocity      <= cfg_wdata[11:0];
        REG_READY_BAND:   cfg_r.ready_band        <= cfg_wdata[7:0];
        REG_READY_DWELL:  cfg_r.ready_dwell_ms    <= cfg_wdata[11:0];
        default: ;
      endcase
    end
  end

  fvf_sequencer u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  fvf_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .ctrl              (ctrl),
    .encoder_count     (in_tdata[31:0]),
    .goal_velocity     (in_tdata[43:32]),
    .stat              (stat),
    .out_valid         (out_tvalid),
    .out_taken         (out_tready),
    .drive_power       (drive_power),
    .measured_velocity (measured_velocity),
    .ready_res         (ready_res)
  );

  assign out_tdata = {ready_res, measured_velocity, drive_power};

  // The program leaves the load step as soon as a tick is taken.
  `FVF_ASSERT_NEXT(a_single_accept, in_tvalid && in_tready, !in_tready, "tick accepted twice")

  // A new result appears only from the emit step of the program.
  `FVF_ASSERT_NOW(a_emit_source, $rose(out_tvalid), $past(ctrl.op) == OP_EMIT, "stray result")

  // No tick is accepted while the divider is iterating.
  `FVF_ASSERT_NOW(a_div_busy, ctrl.op == OP_DIVSTEP, !in_tready, "input taken during division")

endmodule

// File: hdl/fvf_divider.sv
// Restoring serial divider, one quotient bit per step.
// Depends on fvf_pkg for the quotient width.
`timescale 1ns / 1ps

module fvf_divider
  import fvf_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                step,
  input  logic [7:0]          rem_init,
  input  logic [DIV_BITS-1:0] dividend,
  input  logic [7:0]          divisor,
  output logic [DIV_BITS-1:0] quotient,
  output logic                more
);

  logic [7:0]           rem_r, rem_nxt;
  logic [DIV_BITS-1:0]  sh_r, sh_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [8:0]           trial;
  logic                 ge;

  // Bring down the next dividend bit and try the subtraction.
  always_comb begin
    trial   = {rem_r, sh_r[DIV_BITS-1]};
    ge      = trial >= {1'b0, divisor};
    rem_nxt = rem_r;
    sh_nxt  = sh_r;
    cnt_nxt = cnt_r;
    if (start) begin
      rem_nxt = rem_init;
      sh_nxt  = dividend;
      cnt_nxt = DIV_CNT_W'(DIV_BITS - 1);
    end else if (step) begin
      rem_nxt = ge ? 8'(trial - {1'b0, divisor}) : trial[7:0];
      sh_nxt  = {sh_r[DIV_BITS-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    sh_r  <= sh_nxt;
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  assign quotient = sh_r;
  assign more     = cnt_r != '0;

endmodule

// File: hdl/fvf_sequencer.sv
// Microcode sequencer: step counter, program lookup and conditional jumps.
// Depends on fvf_pkg for the program and the control word types.
`timescale 1ns / 1ps

module fvf_sequencer
  import fvf_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  dp_stat_t stat,
  output dp_ctrl_t ctrl
);

  step_t  step_r, step_nxt;
  uword_t cw;
  logic   in_fire;
  logic   jump;

  // Current control word; the input is taken only by the load step.
  always_comb begin
    cw        = ucode_rom(step_r);
    in_tready = cw.op == OP_LOAD;
    in_fire   = in_tready && in_tvalid;
    ctrl      = '{op: cw.op, in_fire: in_fire};
  end

  // Evaluate the jump condition of this step.
  always_comb begin
    case (cw.cond)
      C_NEVER:    jump = 1'b0;
      C_ALWAYS:   jump = 1'b1;
      C_NO_IN:    jump = !in_fire;
      C_DIV_MORE: jump = stat.div_more;
      C_OUT_FULL: jump = stat.out_full;
      default:    jump = 1'b1;
    endcase
    step_nxt = jump ? cw.target : step_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= ST_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

// File: hdl/fvf_datapath.sv
// Datapath of the flywheel controller: velocity, power terms, ready timer
// and the output register. Depends on fvf_pkg and fvf_divider.
`timescale 1ns / 1ps

module fvf_datapath
  import fvf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  dp_ctrl_t    ctrl,
  input  logic [31:0] encoder_count,
  input  logic [11:0] goal_velocity,
  output dp_stat_t    stat,
  output logic        out_valid,
  input  logic        out_taken,
  output logic [6:0]  drive_power,
  output logic [15:0] measured_velocity,
  output logic        ready_res
);

  logic [7:0] period;

  // Tick state.
  logic [31:0] last_count_r;
  logic        primed_r;
  logic        timer_run_r;
  logic [12:0] elapsed_r;
  logic        ready_r;

  // Working registers of one transaction.
  logic [11:0]        goal_r;
  logic               vel_zero_r;
  logic [31:0]        dmag_r;
  logic               dneg_r;
  logic [41:0]        pmag_r;
  logic               sat_r;
  logic signed [15:0] vel_r;
  logic [27:0]        ff_r;
  logic signed [27:0] errp_r;
  logic signed [27:0] errk_r;
  logic               acc_up_r;
  logic               acc_dn_r;
  logic signed [36:0] sum_r;
  logic [6:0]         power_r;

  // Output register.
  logic               out_valid_r;
  logic [6:0]         out_power_r;
  logic [15:0]        out_vel_r;
  logic               out_ready_r;

  // Combinational step results.
  logic [31:0]        delta;
  logic [DIV_BITS-1:0] quo;
  logic               div_more;
  logic signed [15:0] vel_nxt;
  logic signed [17:0] vel_e;
  logic signed [17:0] goal_e;
  logic signed [17:0] err_v;
  logic [27:0]        eabs;
  logic signed [17:0] acc_lo;
  logic signed [17:0] acc_hi;
  logic signed [36:0] acc_v;
  logic signed [20:0] vel_x;
  logic [6:0]         power_nxt;
  logic [16:0]        avel;
  logic signed [17:0] band_hi;
  logic signed [17:0] band_lo;
  logic               in_band;
  logic [13:0]        elapsed_sum;
  logic [12:0]        elapsed_inc;

  assign period = (cfg.loop_period_ms == 8'd0) ? 8'd1 : cfg.loop_period_ms;

  fvf_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (ctrl.op == OP_DIVINIT),
    .step     (ctrl.op == OP_DIVSTEP),
    .rem_init (pmag_r[23:16]),
    .dividend (pmag_r[15:0]),
    .divisor  (period),
    .quotient (quo),
    .more     (div_more)
  );

  // Count change since the last tick; the speed sign is opposite to it.
  assign delta = encoder_count - last_count_r;

  // Speed from quotient, with saturation to the 16-bit range.
  always_comb begin
    if (vel_zero_r) begin
      vel_nxt = '0;
    end else if (sat_r) begin
      vel_nxt = dneg_r ? -16'sd32768 : 16'sd32767;
    end else if (!dneg_r) begin
      vel_nxt = (quo > 16'd32767) ? 16'sd32767 : signed'(quo);
    end else begin
      vel_nxt = (quo > 16'd32768) ? -16'sd32768 : signed'(16'(-{1'b0, quo}));
    end
  end

  // Error and acceleration operands.
  always_comb begin
    vel_e  = 18'(vel_r);
    goal_e = signed'({6'b0, goal_r});
    err_v  = goal_e - vel_e;
    eabs   = errp_r[27] ? 28'(-errp_r) : 28'(errp_r);
    acc_lo = goal_e - signed'({8'b0, cfg.accel_threshold});
    acc_hi = goal_e + signed'({8'b0, cfg.accel_threshold});
    if (acc_up_r) begin
      acc_v = signed'({14'b0, cfg.accel_power, 16'b0});
    end else if (acc_dn_r) begin
      acc_v = -signed'({14'b0, cfg.accel_power, 16'b0});
    end else begin
      acc_v = '0;
    end
  end

  // Power command from the summed terms and the special regions.
  always_comb begin
    vel_x = 21'(vel_r) * 21'(FULL_POWER_DIVISOR);
    if (goal_r == 12'd0) begin
      power_nxt = '0;
    end else if (vel_x < signed'({9'b0, cfg.max_velocity})) begin
      power_nxt = POWER_MAX;
    end else if (sum_r < 0) begin
      power_nxt = POWER_REVERSE;
    end else if (sum_r[36:16] > 21'd127) begin
      power_nxt = POWER_MAX;
    end else begin
      power_nxt = sum_r[22:16];
    end
  end

  // On-speed band test and dwell timer increment.
  always_comb begin
    avel        = vel_r[15] ? 17'(-{vel_r[15], vel_r}) : {1'b0, vel_r};
    band_hi     = goal_e + signed'({10'b0, cfg.ready_band});
    band_lo     = goal_e - signed'({10'b0, cfg.ready_band});
    in_band     = (signed'({1'b0, avel}) < band_hi) && (signed'({1'b0, avel}) > band_lo);
    elapsed_sum = {1'b0, elapsed_r} + {6'b0, period};
    elapsed_inc = elapsed_sum[13] ? ELAPSED_MAX : elapsed_sum[12:0];
  end

  // Working registers, loaded by the step that owns them.
  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_LOAD: begin
        if (ctrl.in_fire) begin
          goal_r     <= goal_velocity;
          vel_zero_r <= !primed_r;
          dmag_r     <= delta[31] ? (~delta + 32'd1) : delta;
          dneg_r     <= !delta[31] && (delta != 32'd0);
        end
      end
      OP_MUL:     pmag_r <= 42'(dmag_r) * 42'(VEL_SCALE);
      OP_DIVINIT: sat_r  <= pmag_r >= {18'b0, period, 16'b0};
      OP_VEL:     vel_r  <= vel_nxt;
      OP_FF:      ff_r   <= 28'(goal_r) * 28'(cfg.velocity_gain_q16);
      OP_ERR:     errp_r <= 28'(err_v) * signed'({18'b0, cfg.error_gain_q8});
      OP_CLIP: begin
        errk_r   <= ({eabs, 8'b0} > {8'b0, ff_r}) ? '0 : errp_r;
        acc_up_r <= vel_e < acc_lo;
        acc_dn_r <= vel_e > acc_hi;
      end
      OP_SUM:  sum_r   <= 37'(ff_r) + acc_v + (37'(errk_r) <<< 8);
      OP_POW:  power_r <= power_nxt;
      default: ;
    endcase
  end

  // Tick state, the ready detector and the output register.
  always_ff @(posedge clk) begin
    if (ctrl.op == OP_EMIT) begin
      out_power_r <= power_r;
      out_vel_r   <= vel_r;
      out_ready_r <= ready_r;
    end
    if (!rst_n) begin
      last_count_r <= '0;
      primed_r     <= 1'b0;
      timer_run_r  <= 1'b0;
      elapsed_r    <= '0;
      ready_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (ctrl.op == OP_LOAD && ctrl.in_fire) begin
        last_count_r <= encoder_count;
        primed_r     <= 1'b1;
      end
      if (ctrl.op == OP_POW) begin
        if (!in_band) begin
          timer_run_r <= 1'b0;
          elapsed_r   <= '0;
          ready_r     <= 1'b0;
        end else if (timer_run_r) begin
          elapsed_r <= elapsed_inc;
          if (elapsed_inc > {1'b0, cfg.ready_dwell_ms}) begin
            ready_r <= 1'b1;
          end
        end else begin
          timer_run_r <= 1'b1;
          elapsed_r   <= '0;
        end
      end
      if (ctrl.op == OP_EMIT) begin
        out_valid_r <= 1'b1;
      end else if (out_taken) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign stat = '{div_more: div_more, out_full: out_valid_r && !out_taken};

  assign out_valid         = out_valid_r;
  assign drive_power       = out_power_r;
  assign measured_velocity = out_vel_r;
  assign ready_res         = out_ready_r;

endmodule

// File: tb/tb_top.sv
// Self-checking bench for the flywheel velocity feedforward controller.
// Drives control ticks over the input stream and checks every result against a typed
// value or a cycle-free software predictor; depends on fvf_pkg and the top level only.
`timescale 1ns / 1ps

module tb_top;
  import fvf_pkg::*;

  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int DRAIN_CYCLES    = 30;
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 160;
  localparam int DIRECTED_ROWS   = 26;

  // One result transaction as it appears on out_tdata.
  typedef struct packed {
    logic              ready;
    logic signed [15:0] vel;
    logic [6:0]        power;
  } tick_result_t;

  // One directed tick; the result is typed in only where it is obvious.
  typedef struct packed {
    logic [31:0]        count;
    logic [11:0]        goal;
    logic               typed;
    logic [6:0]         want_power;
    logic signed [15:0] want_vel;
    logic               want_ready;
  } tick_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [47:0]           in_tdata = '0;   // [31:0] encoder_count, [43:32] goal_velocity
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [23:0]           out_tdata;       // [6:0] drive_power, [22:7] measured_velocity,
                                          // [23] ready_res

  // Predictor state: a shadow of the registers and of the tick history.
  cfg_t        shadow_cfg = CFG_RESET;
  logic [31:0] last_cnt = '0;
  logic        primed = 1'b0;
  logic        band_running = 1'b0;
  int          band_ms = 0;
  logic        ready_flag = 1'b0;

  tick_result_t drive_due[$];
  int           mismatches = 0;
  int           results_seen = 0;
  bit           idle_on = 1'b1;
  int           stall_left = 0;
  tick_row_t    dir_rows [DIRECTED_ROWS];

  flywheel_velocity_feedforward dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Advance the shadow controller by one tick and return its outputs.
  function automatic tick_result_t control_tick(input logic [31:0] cnt, input logic [11:0] goal);
    longint       per, delta, vel, g, thr, acc, ff, err, sum, avel, band;
    logic [31:0]  diff;
    tick_result_t res;
    per = (shadow_cfg.loop_period_ms == 0) ? 1 : longint'(shadow_cfg.loop_period_ms);
    g = longint'(goal);
    vel = 0;
    if (primed) begin
      diff = cnt - last_cnt;
      delta = longint'($signed(diff));
      vel = (-delta * longint'(VEL_SCALE)) / per;
      if (vel > 32767) vel = 32767;
      if (vel < -32768) vel = -32768;
    end
    last_cnt = cnt;
    primed = 1'b1;

    // Drive power: off, full power region, or the summed Q16 terms.
    if (g == 0) begin
      res.power = '0;
    end else if (vel * FULL_POWER_DIVISOR < longint'(shadow_cfg.max_velocity)) begin
      res.power = POWER_MAX;
    end else begin
      thr = longint'(shadow_cfg.accel_threshold);
      if (vel < g - thr) acc = longint'(shadow_cfg.accel_power) * 65536;
      else if (vel > g + thr) acc = -longint'(shadow_cfg.accel_power) * 65536;
      else acc = 0;
      ff = g * longint'(shadow_cfg.velocity_gain_q16);
      err = (g - vel) * longint'(shadow_cfg.error_gain_q8) * 256;
      if ((err < 0 ? -err : err) > (ff < 0 ? -ff : ff)) err = 0;
      sum = ff + acc + err;
      if (sum < 0) res.power = POWER_REVERSE;
      else if ((sum >>> 16) > longint'(POWER_MAX)) res.power = POWER_MAX;
      else res.power = 7'(sum >>> 16);
    end

    // On-speed detector: dwell timer runs while the speed stays in the band.
    avel = (vel < 0) ? -vel : vel;
    band = longint'(shadow_cfg.ready_band);
    if (avel < g + band && avel > g - band) begin
      if (band_running) begin
        band_ms = band_ms + int'(per);
        if (band_ms > int'(ELAPSED_MAX)) band_ms = int'(ELAPSED_MAX);
        if (band_ms > int'(shadow_cfg.ready_dwell_ms)) ready_flag = 1'b1;
      end else begin
        band_running = 1'b1;
        band_ms = 0;
      end
    end else begin
      band_running = 1'b0;
      band_ms = 0;
      ready_flag = 1'b0;
    end

    res.vel = 16'(vel);
    res.ready = ready_flag;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch on %0s at result %0d (%0t): got %0d, expected %0d",
             what, results_seen, $time, got, want);
    mismatches++;
  endtask

  // Register write; called at a falling edge, returns at the next one.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    case (idx)
      REG_LOOP_PERIOD:  shadow_cfg.loop_period_ms = val[7:0];
      REG_ERROR_GAIN:   shadow_cfg.error_gain_q8 = val[9:0];
      REG_VEL_GAIN:     shadow_cfg.velocity_gain_q16 = val[15:0];
      REG_ACCEL_POWER:  shadow_cfg.accel_power = val[6:0];
      REG_ACCEL_THRESH: shadow_cfg.accel_threshold = val[9:0];
      REG_MAX_VEL:      shadow_cfg.max_velocity = val[11:0];
      REG_READY_BAND:   shadow_cfg.ready_band = val[7:0];
      REG_READY_DWELL:  shadow_cfg.ready_dwell_ms = val[11:0];
      default: ;
    endcase
  endtask

  // Register value for a phase: all zeros, all ones, defaults, or random.
  function automatic logic [CFG_DATA_W-1:0] phase_value(input int ph, input logic [15:0] dflt);
    if (ph == 0) return '0;
    if (ph == 1) return '1;
    if (ph == 2 || ph == PHASES - 1) return dflt;
    return CFG_DATA_W'($urandom_range(0, 16'hFFFF));
  endfunction

  // Let the block drain, then load a new register setting.
  task automatic configure_phase(input int ph);
    in_tvalid <= 1'b0;
    while (drive_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    write_reg(REG_LOOP_PERIOD,  phase_value(ph, 16'(CFG_RESET.loop_period_ms)));
    write_reg(REG_ERROR_GAIN,   phase_value(ph, 16'(CFG_RESET.error_gain_q8)));
    write_reg(REG_VEL_GAIN,     phase_value(ph, 16'(CFG_RESET.velocity_gain_q16)));
    write_reg(REG_ACCEL_POWER,  phase_value(ph, 16'(CFG_RESET.accel_power)));
    write_reg(REG_ACCEL_THRESH, phase_value(ph, 16'(CFG_RESET.accel_threshold)));
    write_reg(REG_MAX_VEL,      phase_value(ph, 16'(CFG_RESET.max_velocity)));
    write_reg(REG_READY_BAND,   phase_value(ph, 16'(CFG_RESET.ready_band)));
    write_reg(REG_READY_DWELL,  phase_value(ph, 16'(CFG_RESET.ready_dwell_ms)));
    // An index past the register list must leave every register alone.
    write_reg(REG_READY_DWELL + CFG_IDX_W'(1 + $urandom_range(0, 7)),
              CFG_DATA_W'($urandom_range(0, 16'hFFFF)));
    cfg_we <= 1'b0;
  endtask

  // Offer one tick; called at a falling edge, returns at the falling edge
  // after the transaction.
  task automatic send_tick(input logic [31:0] cnt, input logic [11:0] goal,
                           input logic typed, input tick_result_t want);
    tick_result_t res;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {4'b0, goal, cnt};
    do @(posedge clk); while (!in_tready);
    res = control_tick(cnt, goal);
    drive_due.push_back(typed ? want : res);
    @(negedge clk);
  endtask

  // Receiver with random stall bursts.
  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_on && out_tready && $urandom_range(0, 5) == 0) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 16);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Compare each result transaction with the oldest pending prediction.
  always @(posedge clk) begin : check_results
    tick_result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (drive_due.size() == 0) begin
        report_mismatch("result with nothing pending", longint'(got), 0);
      end else begin
        want = drive_due.pop_front();
        if (got.power !== want.power)
          report_mismatch("drive_power", longint'(got.power), longint'(want.power));
        if (got.vel !== want.vel)
          report_mismatch("measured_velocity", longint'(got.vel), longint'(want.vel));
        if (got.ready !== want.ready)
          report_mismatch("ready_res", longint'(got.ready), longint'(want.ready));
      end
      results_seen++;
    end
  end

  // Watchdog: ends the run when no transaction happens for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $display("FAIL flywheel_velocity_feedforward");
    $finish;
  end

  initial begin : stimulus
    int          ph, k, run_left, goal_cur, v, w, per, mode;
    logic [31:0] enc_pos;
    tick_result_t want;

    // Directed ticks under the reset configuration (period 20 ms, so one
    // count per tick is 30 rpm).
    dir_rows = '{
      // First tick after reset: only primes the count history.
      '{32'h0001_0000, 12'd0,    1'b1, 7'd0,   16'sd0,      1'b0},
      // Standing still with the largest goal: full power region.
      '{32'h0001_0000, 12'd4095, 1'b1, 7'd127, 16'sd0,      1'b0},
      // Count jumps of half the range: velocity saturates both ways.
      '{32'h8001_0000, 12'd0,    1'b1, 7'd0,   16'sd32767,  1'b0},
      '{32'h0000_FFFF, 12'd0,    1'b1, 7'd0,   -16'sd32768, 1'b0},
      // Steady at the goal long enough for ready to rise, then hold.
      '{32'd65435, 12'd3000, 1'b0, 7'd0, 16'sd0, 1'b0},
      '{32'd65335, 12'd3000, 1'b0, 7'd0, 16'sd0, 1'b0},
      '{32'd65235, 12'd3000, 1'b0, 7'd0, 16'sd0, 1'b0},
      '{32'd65135, 12'd3000, 1'b0, 7'd0, 16'sd0, 1'b0},
      '{32'd65035, 12'd3000, 1'b0, 7'd0, 16'sd0, 1'b0},
      '{32'd64935, 12'd3000, 1'b0, 7'd0, 16'sd0, 1'b0},
      '{32'd64835, 12'd3000, 1'b0, 7'd0, 16'sd0, 1'b0},
      '{32'd64735, 12'd3000, 1'b0, 7'd0, 16'sd0, 1'b0},
      '{32'd64635, 12'd3000, 1'b0, 7'd0, 16'sd0, 1'b0},
      '{32'd64535, 12'd3000, 1'b0, 7'd0, 16'sd0, 1'b0},
      // Goal of zero while spinning.
      '{32'd64435, 12'd0,    1'b0, 7'd0, 16'sd0, 1'b0},
      // Far below the goal, then far above it with a negative sum.
      '{32'd64385, 12'd3000, 1'b0, 7'd0, 16'sd0, 1'b0},
      '{32'd64285, 12'd300,  1'b0, 7'd0, 16'sd0, 1'b0},
      // Inside the threshold: proportional term kept, no saturation.
      '{32'd64250, 12'd1000, 1'b0, 7'd0, 16'sd0, 1'b0},
      '{32'd64218, 12'd1000, 1'b0, 7'd0, 16'sd0, 1'b0},
      // Either side of the full power boundary.
      '{32'd64212, 12'd1000, 1'b0, 7'd0, 16'sd0, 1'b0},
      '{32'd64205, 12'd1000, 1'b0, 7'd0, 16'sd0, 1'b0},
      // Running backwards.
      '{32'd64215, 12'd200,  1'b0, 7'd0, 16'sd0, 1'b0},
      // Count differences across the signed and the unsigned wrap points.
      '{32'h8000_0010, 12'd4095, 1'b0, 7'd0, 16'sd0, 1'b0},
      '{32'h7FFF_FFF0, 12'd960,  1'b0, 7'd0, 16'sd0, 1'b0},
      '{32'h0000_0010, 12'd2048, 1'b0, 7'd0, 16'sd0, 1'b0},
      '{32'hFFFF_FFF0, 12'd4095, 1'b0, 7'd0, 16'sd0, 1'b0}
    };

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    for (k = 0; k < DIRECTED_ROWS; k++) begin
      want.power = dir_rows[k].want_power;
      want.vel = dir_rows[k].want_vel;
      want.ready = dir_rows[k].want_ready;
      send_tick(dir_rows[k].count, dir_rows[k].goal, dir_rows[k].typed, want);
    end

    // Random phases: zeros, ones, defaults, random settings, and a final
    // run at the defaults with no idling on either side.
    enc_pos = 32'hFFFF_FFF0;
    run_left = 0;
    goal_cur = 0;
    for (ph = 0; ph < PHASES; ph++) begin
      configure_phase(ph);
      idle_on = (ph % 3 != 2) && (ph != PHASES - 1);
      for (k = 0; k < ITEMS_PER_PHASE; k++) begin
        per = (shadow_cfg.loop_period_ms == 0) ? 1 : int'(shadow_cfg.loop_period_ms);
        if (run_left == 0) begin
          case ($urandom_range(0, 9))
            0:       goal_cur = 0;
            1:       goal_cur = 4095;
            default: goal_cur = int'($urandom_range(1, 4095));
          endcase
          run_left = int'($urandom_range(1, 60));
        end
        run_left--;
        mode = int'($urandom_range(0, 19));
        w = int'(shadow_cfg.ready_band) + 8;
        if (mode < 14) v = goal_cur + int'($urandom_range(0, 2 * w)) - w;
        else v = int'($urandom_range(0, 8000)) - 2000;
        // Mostly a smoothly turning wheel, sometimes encoder noise.
        if (mode == 17 || mode == 18) enc_pos = $urandom();
        else if (mode == 19) enc_pos = enc_pos + 32'(int'($urandom_range(0, 64)) - 32);
        else enc_pos = enc_pos - 32'((v * per) / int'(VEL_SCALE));
        send_tick(enc_pos, 12'(goal_cur), 1'b0, want);
      end
    end

    in_tvalid <= 1'b0;
    while (drive_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("PASS flywheel_velocity_feedforward");
    end else begin
      $display("FAIL flywheel_velocity_feedforward");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+hdl
hdl/fvf_pkg.sv
hdl/fvf_divider.sv
hdl/fvf_sequencer.sv
hdl/fvf_datapath.sv
hdl/flywheel_velocity_feedforward.sv
tb/tb_top.sv
